// File: rtl/tlb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlb_pkg: shared types and constants of the translation buffer
// Widths, operation codes, register indexes, transaction payloads and the
// cell interface types.
// ----------------------------------------------------------------------------
package tlb_pkg;

    localparam int TLB_DEPTH  = 16;
    localparam int PAGE_BITS  = 20;
    localparam int FRAME_BITS = 20;
    localparam int LIMIT_W    = 5;
    localparam int CNT_W      = $clog2(TLB_DEPTH + 1);
    localparam int CMP_W      = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 1'd1;

    typedef enum logic [1:0] {
        FUNC_LOOKUP = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_FLUSH  = 2'd2
    } func_t;

    typedef struct packed {
        func_t                 func;
        logic [PAGE_BITS-1:0]  page;
        logic [FRAME_BITS-1:0] frame;
    } tlb_req_t;

    typedef struct packed {
        logic                  hit;
        logic [FRAME_BITS-1:0] frame_out;
        logic                  evicted;
    } tlb_rsp_t;

    typedef struct packed {
        logic [PAGE_BITS-1:0]  page;
        logic [FRAME_BITS-1:0] frame;
    } entry_t;

    typedef struct packed {
        logic live;
        logic load;
        logic move;
    } cell_ctrl_t;

    typedef struct packed {
        logic                  match_up;
        logic [FRAME_BITS-1:0] frame;
    } chain_t;

endpackage
`default_nettype wire

// File: rtl/tlb_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlb_cell: one age position of the translation buffer
// Holds one entry, compares it with the request page, passes the oldest-match
// chain toward the young end and shifts in its younger neighbor's entry.
// ----------------------------------------------------------------------------
module tlb_cell (
    input  wire                            clk,
    input  wire tlb_pkg::cell_ctrl_t       ctrl,
    input  wire [tlb_pkg::PAGE_BITS-1:0]   cmp_page,
    input  wire tlb_pkg::entry_t           entry_in,
    output tlb_pkg::entry_t                entry_out,
    input  wire tlb_pkg::chain_t           chain_in,
    output tlb_pkg::chain_t                chain_out
);

    tlb_pkg::entry_t entry_reg;
    tlb_pkg::entry_t entry_next;
    logic            match;
    logic            take;
    logic            shift;

    always_comb
    begin
        match              = ctrl.live && (entry_reg.page == cmp_page);
        take               = match && !chain_in.match_up;
        chain_out.match_up = match || chain_in.match_up;
        chain_out.frame    = chain_in.frame | (take ? entry_reg.frame : '0);
        shift              = ctrl.load || (ctrl.move && chain_out.match_up);
        entry_next         = shift ? entry_in : entry_reg;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry_out = entry_reg;

endmodule
`default_nettype wire

// File: rtl/tlb_fifo_lru.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlb_fifo_lru: fully associative translation buffer, FIFO or LRU replacement
//
// Request channel (req_valid, req_stall, req_data) carries lookup, insert
// and flush transactions; a transaction is taken when req_valid is high and
// req_stall is low. Each request yields exactly one response on the rsp
// channel (rsp_valid, rsp_stall, rsp_data) with hit, frame_out and evicted.
// The request register feeds a row of sixteen age cells whose compare and
// oldest-match chain are combinational, and the result lands in the response
// register. One request per cycle is sustained while the response is not
// stalled. A stalled response holds; the request side stalls only when a
// request waits for that register to drain.
// The cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes the
// policy (index 0) and the entry limit (index 1); cfg_ready is always high.
// Write it only while no transaction is in flight.
// Reset empties the buffer, selects FIFO and sets the limit to sixteen.
// ----------------------------------------------------------------------------
module tlb_fifo_lru (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              req_valid,
    output logic                             req_stall,
    input  wire tlb_pkg::tlb_req_t           req_data,
    output logic                             rsp_valid,
    input  wire                              rsp_stall,
    output tlb_pkg::tlb_rsp_t                rsp_data,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire [tlb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [tlb_pkg::LIMIT_W-1:0]       cfg_data
);

    logic                          policy_reg;
    logic [tlb_pkg::LIMIT_W-1:0]   limit_reg;
    logic [tlb_pkg::CNT_W-1:0]     count_reg;
    logic [tlb_pkg::CNT_W-1:0]     count_next;
    logic                          cmd_valid_reg;
    tlb_pkg::tlb_req_t             cmd_reg;
    logic                          rsp_valid_reg;
    tlb_pkg::tlb_rsp_t             rsp_data_reg;
    tlb_pkg::tlb_rsp_t             rsp_data_next;

    logic                          fire;
    logic                          req_take;
    logic                          evict;
    logic [tlb_pkg::CMP_W-1:0]     limit_eff;
    logic                          do_load;
    logic                          do_move;
    tlb_pkg::entry_t               head;

    tlb_pkg::entry_t               entry_q   [tlb_pkg::TLB_DEPTH];
    tlb_pkg::chain_t               chain_q   [tlb_pkg::TLB_DEPTH+1];
    tlb_pkg::cell_ctrl_t           ctrl_q    [tlb_pkg::TLB_DEPTH];

    assign cfg_ready = 1'b1;
    assign fire      = cmd_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = cmd_valid_reg && !fire;
    assign req_take  = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    always_comb
    begin
        priority if (limit_reg == '0)
            limit_eff = tlb_pkg::CMP_W'(1);
        else if (tlb_pkg::CMP_W'(limit_reg) > tlb_pkg::CMP_W'(tlb_pkg::TLB_DEPTH))
            limit_eff = tlb_pkg::CMP_W'(tlb_pkg::TLB_DEPTH);
        else
            limit_eff = tlb_pkg::CMP_W'(limit_reg);
    end

    assign evict   = tlb_pkg::CMP_W'(count_reg) >= limit_eff;
    assign do_load = fire && (cmd_reg.func == tlb_pkg::FUNC_INSERT);
    assign do_move = fire && (cmd_reg.func == tlb_pkg::FUNC_LOOKUP) && policy_reg;

    assign head.page  = cmd_reg.page;
    assign head.frame = (cmd_reg.func == tlb_pkg::FUNC_INSERT) ? cmd_reg.frame
                                                                : chain_q[0].frame;

    assign chain_q[tlb_pkg::TLB_DEPTH] = '0;

    for (genvar k = 0; k < tlb_pkg::TLB_DEPTH; k++)
    begin : g_cell
        tlb_pkg::entry_t entry_in;

        assign ctrl_q[k].live = tlb_pkg::CNT_W'(k) < count_reg;
        assign ctrl_q[k].load = do_load;
        assign ctrl_q[k].move = do_move;

        if (k == 0)
        begin : g_head
            assign entry_in = head;
        end
        else
        begin : g_body
            assign entry_in = entry_q[k-1];
        end

        tlb_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl_q[k]),
            .cmp_page  (cmd_reg.page),
            .entry_in  (entry_in),
            .entry_out (entry_q[k]),
            .chain_in  (chain_q[k+1]),
            .chain_out (chain_q[k])
        );
    end

    always_comb
    begin
        rsp_data_next = '0;
        count_next    = count_reg;
        unique case (cmd_reg.func)
            tlb_pkg::FUNC_LOOKUP:
            begin
                rsp_data_next.hit       = chain_q[0].match_up;
                rsp_data_next.frame_out = chain_q[0].frame;
            end
            tlb_pkg::FUNC_INSERT:
            begin
                rsp_data_next.evicted = evict;
                count_next            = evict ? count_reg : count_reg + 1'b1;
            end
            tlb_pkg::FUNC_FLUSH:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg    <= 1'b0;
            limit_reg     <= tlb_pkg::LIMIT_W'(16);
            count_reg     <= '0;
            cmd_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == tlb_pkg::CFG_POLICY)
                    policy_reg <= cfg_data[0];
                if (cfg_index == tlb_pkg::CFG_LIMIT)
                    limit_reg <= cfg_data;
            end
            if (req_take)
                cmd_valid_reg <= 1'b1;
            else if (fire)
                cmd_valid_reg <= 1'b0;
            if (fire)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
            cmd_reg <= req_data;
        if (fire)
            rsp_data_reg <= rsp_data_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tlb_pkg::CMP_W'(count_reg) <= tlb_pkg::CMP_W'(tlb_pkg::TLB_DEPTH))
        else $error("entry count exceeds buffer depth");

    a_idle_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_valid_reg |-> !req_stall)
        else $error("request stalled with no transaction pending");

    a_hit_only_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (cmd_reg.func != tlb_pkg::FUNC_LOOKUP) |=> !rsp_data_reg.hit)
        else $error("hit reported for a non-lookup transaction");

    a_miss_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !rsp_data_reg.hit |-> rsp_data_reg.frame_out == '0)
        else $error("miss response carries a nonzero frame");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (cmd_reg.func == tlb_pkg::FUNC_INSERT) && !evict
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert without eviction did not grow the count");
`endif

endmodule
`default_nettype wire

// File: tb/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench: translation buffer with FIFO or LRU replacement
// Drives lookup, insert, flush and undefined-operation transactions through
// the request channel, and writes the policy and entry-limit registers
// between phases. A behavioral copy of the buffer tracks entries and their
// age order to predict every response. Each response is checked against the
// oldest prediction. The request channel idles and the response channel stalls
// at random, with quiet stretches in between.
// ----------------------------------------------------------------------------
module testbench;

    localparam tlb_pkg::func_t FUNC_NONE = tlb_pkg::func_t'(2'd3);
    localparam logic [tlb_pkg::PAGE_BITS-1:0] PAGE_MAX   = '1;
    localparam logic [tlb_pkg::FRAME_BITS-1:0] FRAME_MAX = '1;
    localparam int POOL_SIZE = 16;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          req_valid = 1'b0;
    logic                          req_stall;
    tlb_pkg::tlb_req_t             req_data = '0;
    logic                          rsp_valid;
    logic                          rsp_stall = 1'b0;
    tlb_pkg::tlb_rsp_t             rsp_data;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [tlb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [tlb_pkg::LIMIT_W-1:0]   cfg_data = '0;

    tlb_pkg::tlb_rsp_t predicted_rsp[$];
    int mismatches = 0;
    int rsp_taken = 0;
    int rsp_seen = 0;
    int rsp_hold = 0;
    bit req_idle = 1'b0;
    bit rsp_idle = 1'b0;

    // buffer shadow
    bit                             shadow_valid[tlb_pkg::TLB_DEPTH];
    logic [tlb_pkg::PAGE_BITS-1:0]  shadow_page[tlb_pkg::TLB_DEPTH];
    logic [tlb_pkg::FRAME_BITS-1:0] shadow_frame[tlb_pkg::TLB_DEPTH];
    int                             shadow_age[tlb_pkg::TLB_DEPTH];
    int                             shadow_count = 0;
    bit                             lru_mode = 1'b0;
    int                             entry_limit = 16;

    logic [tlb_pkg::PAGE_BITS-1:0] page_pool[POOL_SIZE];

    tlb_fifo_lru DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic void age_younger(input int bound);
        for (int i = 0; i < tlb_pkg::TLB_DEPTH; i++)
        begin
            if (shadow_valid[i] && shadow_age[i] < bound)
                shadow_age[i] = shadow_age[i] + 1;
        end
    endfunction

    function automatic tlb_pkg::tlb_rsp_t predict_response(input tlb_pkg::tlb_req_t r);
        tlb_pkg::tlb_rsp_t rsp;
        int hit_idx;
        int victim;
        int slot;
        int lim;
        int bound;
        rsp = '0;
        hit_idx = -1;
        victim = -1;
        slot = -1;
        case (r.func)
            tlb_pkg::FUNC_LOOKUP:
            begin
                for (int i = 0; i < tlb_pkg::TLB_DEPTH; i++)
                begin
                    if (shadow_valid[i] && shadow_page[i] == r.page &&
                        (hit_idx < 0 || shadow_age[i] > shadow_age[hit_idx]))
                        hit_idx = i;
                end
                if (hit_idx >= 0)
                begin
                    rsp.hit = 1'b1;
                    rsp.frame_out = shadow_frame[hit_idx];
                    if (lru_mode)
                    begin
                        bound = shadow_age[hit_idx];
                        age_younger(bound);
                        shadow_age[hit_idx] = 0;
                    end
                end
            end
            tlb_pkg::FUNC_INSERT:
            begin
                lim = entry_limit < 1 ? 1 :
                      (entry_limit > tlb_pkg::TLB_DEPTH ? tlb_pkg::TLB_DEPTH : entry_limit);
                if (shadow_count >= lim)
                begin
                    for (int i = 0; i < tlb_pkg::TLB_DEPTH; i++)
                    begin
                        if (shadow_valid[i] &&
                            (victim < 0 || shadow_age[i] > shadow_age[victim]))
                            victim = i;
                    end
                    if (victim >= 0)
                    begin
                        shadow_valid[victim] = 1'b0;
                        shadow_count = shadow_count - 1;
                        rsp.evicted = 1'b1;
                    end
                end
                for (int i = tlb_pkg::TLB_DEPTH - 1; i >= 0; i--)
                begin
                    if (!shadow_valid[i])
                        slot = i;
                end
                if (slot >= 0)
                begin
                    age_younger(tlb_pkg::TLB_DEPTH);
                    shadow_valid[slot] = 1'b1;
                    shadow_page[slot] = r.page;
                    shadow_frame[slot] = r.frame;
                    shadow_age[slot] = 0;
                    shadow_count = shadow_count + 1;
                end
            end
            tlb_pkg::FUNC_FLUSH:
            begin
                for (int i = 0; i < tlb_pkg::TLB_DEPTH; i++)
                    shadow_valid[i] = 1'b0;
                shadow_count = 0;
            end
            default:
            begin
            end
        endcase
        return rsp;
    endfunction

    task automatic send_request(input tlb_pkg::func_t f,
                                input logic [tlb_pkg::PAGE_BITS-1:0] p,
                                input logic [tlb_pkg::FRAME_BITS-1:0] fr);
        tlb_pkg::tlb_req_t r;
        int gap;
        r.func = f;
        r.page = p;
        r.frame = fr;
        gap = req_idle ? $urandom_range(0, 12) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data <= r;
        do
            @(posedge clk);
        while (req_stall);
        predicted_rsp.push_back(predict_response(r));
    endtask

    task automatic wait_until_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (predicted_rsp.size() != 0)
            @(posedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input logic [tlb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tlb_pkg::LIMIT_W-1:0] value);
        wait_until_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == tlb_pkg::CFG_POLICY)
            lru_mode = value[0];
        else
            entry_limit = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // response check
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            rsp_taken = rsp_taken + 1;
            if (predicted_rsp.size() == 0)
            begin
                $error("response with no transaction pending");
                mismatches = mismatches + 1;
            end
            else if (predicted_rsp[0] !== rsp_data)
            begin
                if (predicted_rsp[0].hit !== rsp_data.hit)
                    $error("hit: expected %0d, got %0d", predicted_rsp[0].hit, rsp_data.hit);
                if (predicted_rsp[0].frame_out !== rsp_data.frame_out)
                    $error("frame_out: expected %0h, got %0h",
                           predicted_rsp[0].frame_out, rsp_data.frame_out);
                if (predicted_rsp[0].evicted !== rsp_data.evicted)
                    $error("evicted: expected %0d, got %0d",
                           predicted_rsp[0].evicted, rsp_data.evicted);
                mismatches = mismatches + 1;
                void'(predicted_rsp.pop_front());
            end
            else
                void'(predicted_rsp.pop_front());
        end
    end

    // response back-pressure
    always @(negedge clk)
    begin
        if (rsp_taken != rsp_seen)
        begin
            rsp_seen = rsp_taken;
            rsp_hold = rsp_idle ? $urandom_range(0, 12) : 0;
        end
        if (rsp_hold > 0)
        begin
            rsp_stall <= 1'b1;
            rsp_hold = rsp_hold - 1;
        end
        else
            rsp_stall <= 1'b0;
    end

    task automatic test_empty_buffer();
        send_request(tlb_pkg::FUNC_LOOKUP, '0, '0);
        send_request(tlb_pkg::FUNC_LOOKUP, PAGE_MAX, FRAME_MAX);
        send_request(tlb_pkg::FUNC_FLUSH, PAGE_MAX, FRAME_MAX);
        send_request(FUNC_NONE, PAGE_MAX, FRAME_MAX);
    endtask

    task automatic test_fifo_duplicates();
        send_request(tlb_pkg::FUNC_INSERT, '0, FRAME_MAX);
        send_request(tlb_pkg::FUNC_INSERT, PAGE_MAX, '0);
        send_request(tlb_pkg::FUNC_INSERT, '0, 20'h12345);
        send_request(tlb_pkg::FUNC_LOOKUP, '0, '0);
        send_request(tlb_pkg::FUNC_LOOKUP, PAGE_MAX, '0);
        send_request(FUNC_NONE, '0, '0);
        send_request(tlb_pkg::FUNC_FLUSH, '0, '0);
        send_request(tlb_pkg::FUNC_LOOKUP, '0, '0);
    endtask

    task automatic test_limit_clamp();
        write_reg(tlb_pkg::CFG_LIMIT, 5'd0);
        send_request(tlb_pkg::FUNC_INSERT, 20'h00011, 20'hA0001);
        send_request(tlb_pkg::FUNC_INSERT, 20'h00022, 20'hA0002);
        send_request(tlb_pkg::FUNC_LOOKUP, 20'h00011, '0);
        send_request(tlb_pkg::FUNC_LOOKUP, 20'h00022, '0);
        write_reg(tlb_pkg::CFG_LIMIT, 5'd31);
        send_request(tlb_pkg::FUNC_INSERT, 20'h00033, 20'hA0003);
        send_request(tlb_pkg::FUNC_LOOKUP, 20'h00022, '0);
    endtask

    task automatic test_lru_order();
        write_reg(tlb_pkg::CFG_POLICY, 5'b11111);
        write_reg(tlb_pkg::CFG_LIMIT, 5'd2);
        send_request(tlb_pkg::FUNC_FLUSH, '0, '0);
        send_request(tlb_pkg::FUNC_INSERT, 20'h00100, 20'hB0001);
        send_request(tlb_pkg::FUNC_INSERT, 20'h00200, 20'hB0002);
        send_request(tlb_pkg::FUNC_LOOKUP, 20'h00100, '0);
        send_request(tlb_pkg::FUNC_INSERT, 20'h00300, 20'hB0003);
        send_request(tlb_pkg::FUNC_LOOKUP, 20'h00200, '0);
        send_request(tlb_pkg::FUNC_LOOKUP, 20'h00100, '0);
    endtask

    task automatic test_limit_lowered();
        write_reg(tlb_pkg::CFG_POLICY, 5'b11110);
        write_reg(tlb_pkg::CFG_LIMIT, 5'd16);
        send_request(tlb_pkg::FUNC_INSERT, 20'h00400, 20'hC0001);
        send_request(tlb_pkg::FUNC_INSERT, 20'h00500, 20'hC0002);
        write_reg(tlb_pkg::CFG_LIMIT, 5'd1);
        send_request(tlb_pkg::FUNC_INSERT, 20'h00600, 20'hC0003);
        send_request(tlb_pkg::FUNC_INSERT, 20'h00700, 20'hC0004);
        send_request(tlb_pkg::FUNC_LOOKUP, 20'h00100, '0);
        send_request(tlb_pkg::FUNC_LOOKUP, 20'h00600, '0);
    endtask

    task automatic test_random_traffic();
        int limit_plan[10];
        logic [tlb_pkg::PAGE_BITS-1:0] p;
        int sel;
        tlb_pkg::func_t f;
        limit_plan = '{31, 1, 0, 16, 4, 8, 2, 12, 17, 3};
        for (int ph = 0; ph < 10; ph++)
        begin
            write_reg(tlb_pkg::CFG_POLICY, tlb_pkg::LIMIT_W'($urandom));
            write_reg(tlb_pkg::CFG_LIMIT, tlb_pkg::LIMIT_W'(limit_plan[ph]));
            page_pool[0] = '0;
            page_pool[1] = PAGE_MAX;
            for (int k = 2; k < POOL_SIZE; k++)
                page_pool[k] = tlb_pkg::PAGE_BITS'($urandom);
            for (int n = 0; n < 115; n++)
            begin
                if (n % 40 == 0)
                begin
                    req_idle = ($urandom_range(0, 3) != 0);
                    rsp_idle = ($urandom_range(0, 3) != 0);
                end
                if (ph == 4 && n == 60)
                    wait_until_drained();
                sel = $urandom_range(0, 99);
                if (sel < 50)
                    f = tlb_pkg::FUNC_LOOKUP;
                else if (sel < 96)
                    f = tlb_pkg::FUNC_INSERT;
                else if (sel < 98)
                    f = tlb_pkg::FUNC_FLUSH;
                else
                    f = FUNC_NONE;
                p = ($urandom_range(0, 9) != 0) ? page_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                : tlb_pkg::PAGE_BITS'($urandom);
                send_request(f, p, tlb_pkg::FRAME_BITS'($urandom));
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < tlb_pkg::TLB_DEPTH; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_page[i] = '0;
            shadow_frame[i] = '0;
            shadow_age[i] = 0;
        end
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        test_empty_buffer();
        req_idle = 1'b1;
        rsp_idle = 1'b1;
        test_fifo_duplicates();
        test_limit_clamp();
        test_lru_order();
        test_limit_lowered();
        test_random_traffic();
        wait_until_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && predicted_rsp.size() == 0)
            $display("tlb_fifo_lru test passed");
        else
            $display("tlb_fifo_lru test failed");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("tlb_fifo_lru test failed");
        $finish;
    end

endmodule
`default_nettype wire

// File: sim.f
rtl/tlb_pkg.sv
rtl/tlb_cell.sv
rtl/tlb_fifo_lru.sv
tb/testbench.sv
